FILE: hw/rtl/mxt_pkg.sv
// -----------------------------------------------------------------------------
// Maximum XOR subarray trie package
// Shared constants and the token that travels along the chain of trie cells.
// -----------------------------------------------------------------------------
package mxt_pkg;

	// Key width, one trie cell per key bit.
	localparam int KEY_BITS   = 32;
	localparam int MAX_ITEMS  = 1024;
	// Node budget of the whole trie, leaves included.
	localparam int POOL_NODES = MAX_ITEMS * KEY_BITS + 1;
	localparam int PTR_W      = 16;
	localparam int LVL_W      = $clog2(KEY_BITS + 1);
	localparam int CNT_W      = 16;

	// Token handed from one cell to the next.
	typedef struct packed {
		logic                vld;
		logic                ins;    // 1: insert walk, 0: lookup walk
		logic [KEY_BITS-1:0] key;    // shifted left by one in each cell
		logic [PTR_W-1:0]    qptr;   // node of the query walk
		logic                qdead;  // query walk hit a node without children
		logic [KEY_BITS-1:0] qres;   // query result, filled from the top bit
		logic [PTR_W-1:0]    iptr;   // node of the insert path
		logic                ifresh; // insert path node was allocated just now
		logic [LVL_W-1:0]    need;   // nodes an insert needs, 0 while path exists
		logic [LVL_W-1:0]    lvl;    // depth of the cell that receives the token
	} tok_t;

endpackage

FILE: hw/rtl/mxt_if.sv
// -----------------------------------------------------------------------------
// Maximum XOR subarray trie channels
// Valid/ready channels for input elements and result requests.
// -----------------------------------------------------------------------------
interface mxt_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] element;
	logic        last_item;

	modport source(output valid, element, last_item, input ready);
	modport sink(input valid, element, last_item, output ready);
endinterface

interface mxt_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] best_xor;
	logic        pool_full;
	logic        array_done;

	modport source(output valid, best_xor, pool_full, array_done, input ready);
	modport sink(input valid, best_xor, pool_full, array_done, output ready);
endinterface

FILE: hw/rtl/mxt_cell.sv
// -----------------------------------------------------------------------------
// Trie cell
// Holds the trie nodes of one depth and handles one key bit of each walk.
// -----------------------------------------------------------------------------
module mxt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  mxt_pkg::tok_t tok_i,
	output mxt_pkg::tok_t tok_o
);

	// Child pairs of this depth: low half the 0-child, high half the 1-child.
	logic [2*mxt_pkg::PTR_W-1:0] mem_q [0:mxt_pkg::POOL_NODES-1];
	logic [2*mxt_pkg::PTR_W-1:0] rda_q, rdb_q;
	mxt_pkg::tok_t               tok_q, tok_oq, nxt;
	logic [mxt_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	logic                        we;
	logic [mxt_pkg::PTR_W-1:0]   wa;
	logic [2*mxt_pkg::PTR_W-1:0] wd, e;
	logic [mxt_pkg::PTR_W-1:0]   opp, same, c;
	logic                        b;

	// Node memory with two registered read ports and one write port.
	always_ff @(posedge clk) begin
		rda_q <= mem_q[tok_i.qptr];
		rdb_q <= mem_q[tok_i.iptr];
		if (clr) begin
			mem_q[0] <= '0;
		end else if (we) begin
			mem_q[wa] <= wd;
		end
	end

	// Token waits here for the read data, then moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= '0;
			tok_oq <= '0;
			cnt_q  <= '0;
		end else begin
			tok_q  <= tok_i;
			tok_oq <= nxt;
			cnt_q  <= clr ? '0 : cnt_d;
		end
	end

	// One key bit of the lookup or insert walk.
	always_comb begin
		nxt      = tok_q;
		nxt.key  = tok_q.key << 1;
		nxt.lvl  = tok_q.lvl + 1'b1;
		nxt.qres = tok_q.qres << 1;
		we       = 1'b0;
		wa       = tok_q.iptr;
		wd       = '0;
		cnt_d    = cnt_q;
		b        = tok_q.key[mxt_pkg::KEY_BITS-1];
		opp      = b ? rda_q[mxt_pkg::PTR_W-1:0] : rda_q[2*mxt_pkg::PTR_W-1:mxt_pkg::PTR_W];
		same     = b ? rda_q[2*mxt_pkg::PTR_W-1:mxt_pkg::PTR_W] : rda_q[mxt_pkg::PTR_W-1:0];
		e        = tok_q.ifresh ? '0 : rdb_q;
		c        = b ? e[2*mxt_pkg::PTR_W-1:mxt_pkg::PTR_W] : e[mxt_pkg::PTR_W-1:0];
		if (tok_q.vld) begin
			if (!tok_q.ins) begin
				// Query prefers the opposite bit; existence check follows the key.
				if (!tok_q.qdead) begin
					if (opp != '0) begin
						nxt.qres[0] = 1'b1;
						nxt.qptr    = opp;
					end else if (same != '0) begin
						nxt.qptr = same;
					end else begin
						nxt.qdead = 1'b1;
					end
				end
				if (tok_q.need == '0) begin
					if (c == '0) begin
						nxt.need = mxt_pkg::LVL_W'(mxt_pkg::KEY_BITS) - tok_q.lvl;
					end else begin
						nxt.iptr = c;
					end
				end
			end else begin
				// Insert allocates the next child where the path ends.
				if (c == '0) begin
					cnt_d       = cnt_q + 1'b1;
					we          = 1'b1;
					wd          = b ? {cnt_d, e[mxt_pkg::PTR_W-1:0]}
					                : {e[2*mxt_pkg::PTR_W-1:mxt_pkg::PTR_W], cnt_d};
					nxt.iptr    = cnt_d;
					nxt.ifresh  = 1'b1;
				end else begin
					nxt.iptr   = c;
					nxt.ifresh = 1'b0;
				end
			end
		end
	end

	assign tok_o = tok_oq;

endmodule

FILE: hw/rtl/max_xor_subarray_trie_unit.sv
// -----------------------------------------------------------------------------
// Maximum XOR subarray trie unit
// Running maximum subarray XOR per element, using a binary trie of prefixes.
// -----------------------------------------------------------------------------
// The trie is a chain of 32 cells, one per key bit, and each cell has its own
// node memory. A walk passes each cell as a registered read, then an update.
// An element takes a lookup walk and then an insert walk. Its result is
// loaded into the output register after the insert walk, and the next request
// is accepted once the sequencer is back in idle. The first element of an
// array adds a clear state and the insert walk of the zero prefix. When the
// node pool runs out, the insert walk is skipped, pool_full is set for that
// result, and the result follows the lookup walk. One element is in work at a
// time. The next request is taken while a result still waits in the output
// register, and a new result that finds that register still full waits until
// the old one is taken.
module max_xor_subarray_trie_unit (
	input  logic       clk,
	input  logic       arst_n,
	mxt_in_if.sink     in_chan,
	mxt_out_if.source  out_chan
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_CLR  = 6'b000010,
		S_INS0 = 6'b000100,
		S_LOOK = 6'b001000,
		S_INS  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t                       state_q;
	mxt_pkg::tok_t                tok [0:mxt_pkg::KEY_BITS];
	mxt_pkg::tok_t                launch_q, launch_d;
	logic [mxt_pkg::KEY_BITS-1:0] elem_q, prefix_q, best_q;
	logic                         last_q, full_q, open_q;
	logic [mxt_pkg::CNT_W-1:0]    nodes_q;
	logic                         out_vld_q, out_full_q, out_done_q;
	logic [mxt_pkg::KEY_BITS-1:0] out_best_q;
	logic                         clr;
	logic                         fits;
	mxt_pkg::tok_t                end_tok;

	assign clr     = (state_q == S_CLR);
	assign end_tok = tok[mxt_pkg::KEY_BITS];
	assign fits    = ({1'b0, nodes_q} + (mxt_pkg::CNT_W+1)'(end_tok.need))
	                 <= (mxt_pkg::CNT_W+1)'(mxt_pkg::POOL_NODES);
	assign tok[0]  = launch_q;

	// Chain of trie cells, one per key bit.
	for (genvar g = 0; g < mxt_pkg::KEY_BITS; g++) begin : g_cell
		mxt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.clr    (clr),
			.tok_i  (tok[g]),
			.tok_o  (tok[g+1])
		);
	end

	// Token that enters the chain next cycle, if any.
	always_comb begin
		launch_d = '0;
		case (state_q)
			S_IDLE: begin
				if (in_chan.valid && open_q) begin
					launch_d.vld = 1'b1;
					launch_d.key = prefix_q ^ in_chan.element;
				end
			end
			S_CLR: begin
				launch_d.vld = 1'b1;
				launch_d.ins = 1'b1;
			end
			S_INS0: begin
				if (end_tok.vld) begin
					launch_d.vld = 1'b1;
					launch_d.key = elem_q;
				end
			end
			S_LOOK: begin
				if (end_tok.vld && fits) begin
					launch_d.vld = 1'b1;
					launch_d.ins = 1'b1;
					launch_d.key = prefix_q;
				end
			end
			default: begin
				launch_d = '0;
			end
		endcase
	end

	// Sequencer for array start, lookup and insert walks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			launch_q   <= '0;
			prefix_q   <= '0;
			best_q     <= '0;
			nodes_q    <= mxt_pkg::CNT_W'(1);
			open_q     <= 1'b0;
			full_q     <= 1'b0;
			elem_q     <= '0;
			last_q     <= 1'b0;
			out_vld_q  <= 1'b0;
			out_best_q <= '0;
			out_full_q <= 1'b0;
			out_done_q <= 1'b0;
		end else begin
			launch_q <= launch_d;
			if (out_vld_q && out_chan.ready && state_q != S_DONE) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_chan.valid) begin
						elem_q <= in_chan.element;
						last_q <= in_chan.last_item;
						if (!open_q) begin
							state_q  <= S_CLR;
							prefix_q <= '0;
							best_q   <= '0;
						end else begin
							prefix_q <= prefix_q ^ in_chan.element;
							state_q  <= S_LOOK;
						end
					end
				end
				S_CLR: begin
					// Root is cleared this cycle; the zero prefix follows.
					nodes_q <= mxt_pkg::CNT_W'(mxt_pkg::KEY_BITS + 1);
					open_q  <= 1'b1;
					state_q <= S_INS0;
				end
				S_INS0: begin
					if (end_tok.vld) begin
						prefix_q <= elem_q;
						state_q  <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (end_tok.vld) begin
						if (end_tok.qres > best_q) begin
							best_q <= end_tok.qres;
						end
						if (fits) begin
							nodes_q <= nodes_q + mxt_pkg::CNT_W'(end_tok.need);
							full_q  <= 1'b0;
							state_q <= S_INS;
						end else begin
							full_q  <= 1'b1;
							state_q <= S_DONE;
						end
					end
				end
				S_INS: begin
					if (end_tok.vld) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_vld_q || out_chan.ready) begin
						out_vld_q  <= 1'b1;
						out_best_q <= best_q;
						out_full_q <= full_q;
						out_done_q <= last_q;
						open_q     <= !last_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_chan.ready       = (state_q == S_IDLE);
	assign out_chan.valid      = out_vld_q;
	assign out_chan.best_xor   = out_best_q;
	assign out_chan.pool_full  = out_full_q;
	assign out_chan.array_done = out_done_q;

	// A new result comes only from the final state of an item.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == S_DONE))
		else $error("result loaded outside of final state");

	// The node count never exceeds the pool.
	a_pool: assert property (@(posedge clk) disable iff (!arst_n)
		nodes_q <= mxt_pkg::CNT_W'(mxt_pkg::POOL_NODES))
		else $error("node count beyond pool");

	// A walk only leaves the chain while the sequencer waits for it.
	a_walk: assert property (@(posedge clk) disable iff (!arst_n)
		end_tok.vld |-> (state_q == S_INS0 || state_q == S_LOOK || state_q == S_INS))
		else $error("walk finished in an unexpected state");

endmodule
